// ===== rtl/qts_pkg.sv =====
// qts_pkg: shared types, codes and constants for the quoted token splitter
// holds transaction payload structs, scan state, result bundles and queue status
// no dependencies
package qts_pkg;

    localparam int NUM_DELIMS  = 4;
    localparam int REG_DELIMS  = 4;
    localparam int DELIM_SLOTS = (NUM_DELIMS < REG_DELIMS) ? NUM_DELIMS : REG_DELIMS;
    localparam int CFG_WIDTH   = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int MAX_RESULTS = 4;
    localparam int RES_IW      = $clog2(MAX_RESULTS);
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int MAX_PASSES  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // character codes
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_COMMENT,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_ESC_FIRST,
        MODE_ESC_OCTAL
    } scan_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SKIP_FLAGS,
        CFG_DELIM_A,
        CFG_DELIM_B,
        CFG_DELIM_C,
        CFG_DELIM_D
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_STOP,
        KIND_EOS
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        result_t [MAX_RESULTS-1:0]         res;
    } bundle_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [7:0]  quote_byte;
        logic [1:0]  esc_left;
        logic [8:0]  esc_value;
        logic        esc_in_quotes;
        logic        has_bytes;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]                  skip_flags;
        logic [REG_DELIMS-1:0][7:0]  delim;
    } skip_cfg_t;

    typedef struct packed {
        scan_state_t    st;
        logic           rescan;
        logic [1:0]     n_emit;
        result_t [1:0]  em;
    } pass_out_t;

    typedef struct packed {
        logic                full;
        logic                not_empty;
        logic [QUEUE_AW:0]   level;
    } q_status_t;

endpackage

// ===== rtl/qts_front.sv =====
// qts_front: configuration registers and byte classifier of the quoted token splitter
// turns each accepted byte into a bundle of results and updates the scan state
// depends on qts_pkg
module qts_front
    import qts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_item_t                in_data,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_wdata,
    input  q_status_t               q_stat,
    output logic                    push,
    output bundle_t                 push_data,
    output scan_mode_t              mode
);

    skip_cfg_t   cfg_reg, cfg_next;
    scan_state_t state_reg, state_next;
    scan_state_t walk;
    pass_out_t   p;
    bundle_t     bundle;
    logic        active;
    logic        accept;

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_delim(skip_cfg_t c, logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < DELIM_SLOTS; i++)
        begin
            if (c.delim[i] != 8'd0 && c.delim[i] == b)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic is_octal(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    // finish an escape: one byte out, back to the string or plain token
    function automatic pass_out_t esc_done(pass_out_t pi, logic [7:0] b);
        pass_out_t po;
        po = pi;
        po.em[0]           = '{kind: KIND_BYTE, out_byte: b};
        po.n_emit          = 2'd1;
        po.st.has_bytes    = 1'b1;
        po.st.esc_left     = 2'd0;
        po.st.esc_value    = 9'd0;
        po.st.mode         = pi.st.esc_in_quotes ? MODE_QUOTED : MODE_PLAIN;
        return po;
    endfunction

    // one scan step; rescan asks for the same byte again in the new mode
    function automatic pass_out_t scan_pass(scan_state_t s, skip_cfg_t c, logic [7:0] b);
        pass_out_t  po;
        logic [8:0] oct_val;
        logic [1:0] oct_left;
        logic [7:0] esc_byte;
        po        = '0;
        po.st     = s;
        oct_val   = {s.esc_value[5:0], b[2:0]};
        oct_left  = s.esc_left - 2'd1;
        esc_byte  = b;
        unique case (s.mode)
            MODE_SKIP:
            begin
                priority if (b == CH_SPACE || b == CH_TAB)
                begin
                    po.n_emit = 2'd0;
                end
                else if (b == CH_LF)
                begin
                    if (c.skip_flags[0])
                    begin
                        po.em[0]  = '{kind: KIND_STOP, out_byte: b};
                        po.n_emit = 2'd1;
                    end
                end
                else if (b == CH_HASH && !c.skip_flags[1])
                begin
                    po.st.mode = MODE_COMMENT;
                end
                else if (is_space(b))
                begin
                    po.em[0]  = '{kind: KIND_STOP, out_byte: b};
                    po.n_emit = 2'd1;
                end
                else if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    po.st.has_bytes  = 1'b0;
                    po.st.mode       = MODE_QUOTED;
                    po.st.quote_byte = b;
                end
                else
                begin
                    po.st.has_bytes = 1'b0;
                    po.st.mode      = MODE_PLAIN;
                    po.rescan       = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_LF)
                begin
                    po.st.mode = MODE_SKIP;
                    po.rescan  = 1'b1;
                end
            end
            MODE_PLAIN:
            begin
                priority if (is_space(b))
                begin
                    po.em[0]   = '{kind: KIND_END, out_byte: 8'd0};
                    po.n_emit  = 2'd1;
                    po.st.mode = MODE_SKIP;
                end
                else if (b == CH_BSLASH)
                begin
                    po.st.mode          = MODE_ESC_FIRST;
                    po.st.esc_in_quotes = 1'b0;
                end
                else if (is_delim(c, b))
                begin
                    po.st.mode = MODE_SKIP;
                    if (s.has_bytes)
                    begin
                        po.em[0]  = '{kind: KIND_END, out_byte: 8'd0};
                        po.n_emit = 2'd1;
                        po.rescan = 1'b1;
                    end
                    else
                    begin
                        // delimiter at token start is a token of its own
                        po.em[0]  = '{kind: KIND_BYTE, out_byte: b};
                        po.em[1]  = '{kind: KIND_END, out_byte: 8'd0};
                        po.n_emit = 2'd2;
                    end
                end
                else
                begin
                    po.em[0]        = '{kind: KIND_BYTE, out_byte: b};
                    po.n_emit       = 2'd1;
                    po.st.has_bytes = 1'b1;
                end
            end
            MODE_QUOTED:
            begin
                priority if (b == s.quote_byte)
                begin
                    po.em[0]   = '{kind: KIND_END, out_byte: 8'd0};
                    po.n_emit  = 2'd1;
                    po.st.mode = MODE_SKIP;
                end
                else if (b == CH_BSLASH)
                begin
                    po.st.mode          = MODE_ESC_FIRST;
                    po.st.esc_in_quotes = 1'b1;
                end
                else
                begin
                    po.em[0]        = '{kind: KIND_BYTE, out_byte: b};
                    po.n_emit       = 2'd1;
                    po.st.has_bytes = 1'b1;
                end
            end
            MODE_ESC_FIRST:
            begin
                if (is_octal(b))
                begin
                    po.st.esc_value = {6'd0, b[2:0]};
                    po.st.esc_left  = 2'd2;
                    po.st.mode      = MODE_ESC_OCTAL;
                end
                else
                begin
                    priority if (b == CH_LOW_N)
                        esc_byte = CH_LF;
                    else if (b == CH_LOW_B)
                        esc_byte = CH_BS;
                    else if (b == CH_LOW_T)
                        esc_byte = CH_TAB;
                    else if (b == CH_LOW_R)
                        esc_byte = CH_CR;
                    else
                        esc_byte = b;
                    po = esc_done(po, esc_byte);
                end
            end
            MODE_ESC_OCTAL:
            begin
                if (is_octal(b))
                begin
                    if (oct_left == 2'd0)
                    begin
                        po = esc_done(po, oct_val[7:0]);
                    end
                    else
                    begin
                        po.st.esc_value = oct_val;
                        po.st.esc_left  = oct_left;
                    end
                end
                else
                begin
                    // octal run cut short: value out, byte scanned again
                    po        = esc_done(po, s.esc_value[7:0]);
                    po.rescan = 1'b1;
                end
            end
            default:
            begin
                po.st.mode = MODE_SKIP;
                po.rescan  = 1'b1;
            end
        endcase
        return po;
    endfunction

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign mode     = state_reg.mode;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SKIP_FLAGS: cfg_next.skip_flags = cfg_wdata[1:0];
                CFG_DELIM_A:    cfg_next.delim[0]   = cfg_wdata;
                CFG_DELIM_B:    cfg_next.delim[1]   = cfg_wdata;
                CFG_DELIM_C:    cfg_next.delim[2]   = cfg_wdata;
                CFG_DELIM_D:    cfg_next.delim[3]   = cfg_wdata;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    // classify the byte: a short chain of rescans, results gathered in order
    always_comb
    begin
        walk   = state_reg;
        bundle = '0;
        active = 1'b1;
        p      = '0;
        if (in_data.end_of_input)
        begin
            if (state_reg.mode == MODE_ESC_OCTAL)
            begin
                bundle.res[bundle.count[RES_IW-1:0]] =
                    '{kind: KIND_BYTE, out_byte: state_reg.esc_value[7:0]};
                bundle.count = bundle.count + COUNT_W'(1);
            end
            if (state_reg.mode == MODE_PLAIN || state_reg.mode == MODE_QUOTED ||
                state_reg.mode == MODE_ESC_FIRST || state_reg.mode == MODE_ESC_OCTAL)
            begin
                bundle.res[bundle.count[RES_IW-1:0]] = '{kind: KIND_END, out_byte: 8'd0};
                bundle.count = bundle.count + COUNT_W'(1);
            end
            bundle.res[bundle.count[RES_IW-1:0]] = '{kind: KIND_EOS, out_byte: 8'd0};
            bundle.count = bundle.count + COUNT_W'(1);
            walk         = '0;
            walk.mode    = MODE_SKIP;
        end
        else
        begin
            for (int k = 0; k < MAX_PASSES; k++)
            begin
                if (active)
                begin
                    p    = scan_pass(walk, cfg_reg, in_data.in_byte);
                    walk = p.st;
                    for (int j = 0; j < 2; j++)
                    begin
                        if (j < int'(p.n_emit) && bundle.count < COUNT_W'(MAX_RESULTS))
                        begin
                            bundle.res[bundle.count[RES_IW-1:0]] = p.em[j];
                            bundle.count = bundle.count + COUNT_W'(1);
                        end
                    end
                    active = p.rescan;
                end
            end
        end
        state_next = accept ? walk : state_reg;
    end

    assign push      = accept && (bundle.count != '0);
    assign push_data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            state_reg <= '{mode: MODE_SKIP, quote_byte: 8'd0, esc_left: 2'd0,
                           esc_value: 9'd0, esc_in_quotes: 1'b0, has_bytes: 1'b0};
        end
        else
        begin
            cfg_reg   <= cfg_next;
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/qts_queue.sv =====
// qts_queue: short bundle queue between classifier and result serialiser
// register array with read and write pointers and a fill level
// depends on qts_pkg
module qts_queue
    import qts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bundle_t    push_data,
    input  logic       pop,
    output bundle_t    head,
    output q_status_t  q_stat
);

    bundle_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   level_reg, level_next;
    logic                do_push, do_pop;

    assign q_stat.full      = (level_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_stat.not_empty = (level_reg != '0);
    assign q_stat.level     = level_reg;
    assign head             = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
            level_next = level_reg + (QUEUE_AW + 1)'(1);
        else if (do_pop && !do_push)
            level_next = level_reg - (QUEUE_AW + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== rtl/qts_back.sv =====
// qts_back: result serialiser of the quoted token splitter
// walks the head bundle one result a cycle into the output register while the output is not stalled
// depends on qts_pkg
module qts_back
    import qts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_stat,
    input  bundle_t    head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    out_data
);

    logic [RES_IW-1:0] idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;
    logic              load;
    logic              last;

    assign load = q_stat.not_empty && (!out_valid_reg || !out_stall);
    assign last = (COUNT_W'(idx_reg) + COUNT_W'(1)) == head.count;
    assign pop  = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = head.res[idx_reg];
            idx_next       = last ? '0 : idx_reg + RES_IW'(1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/quoted_token_splitter_core.sv =====
// throughput: one byte transaction per cycle while the bundle queue has room; results
// leave at one per cycle through the output register while the output is not stalled.
// the first result of a byte passes through the bundle queue, then the output register.
// the queue (four bundles) sets how long the input runs on under a stalled output.
// reset: asynchronous active low; scan state, config registers, queue pointers and output valid clear
// depends on qts_pkg, qts_front, qts_queue, qts_back
module quoted_token_splitter_core
    import qts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // byte stream transactions
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_item_t                in_data,
    // result transactions
    output logic                    out_valid,
    input  logic                    out_stall,
    output result_t                 out_data,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]    cfg_wdata
);

    // front to queue: one bundle of up to four results per byte
    logic        push;
    bundle_t     push_data;
    // queue to back
    logic        pop;
    bundle_t     head;
    q_status_t   q_stat;
    // scan mode for checking only
    scan_mode_t  front_mode;

    // front: classifier, scan state and the configuration registers
    qts_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data),
        .mode      (front_mode)
    );

    // decoupling queue, bytes giving no result push nothing
    qts_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // back: serialise the head bundle into the output register
    qts_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // end of stream always leaves the scanner between tokens
    a_eos_to_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.end_of_input) |=> (front_mode == MODE_SKIP))
        else $error("scan state not cleared after end of stream");

    // bundles pushed hold between one and four results
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_data.count != '0 && push_data.count <= COUNT_W'(MAX_RESULTS)))
        else $error("bad bundle count pushed");

    // the back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.not_empty)
        else $error("pop from empty queue");

    // fill level stays within the queue depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue level out of range");

endmodule

// ===== test/quoted_token_splitter_core_tb.sv =====
// testbench for quoted_token_splitter_core: directed rows, then random text in config phases
// checks every result transaction against typed results or a behavioural tokeniser kept in this file
// depends on qts_pkg and quoted_token_splitter_core
module quoted_token_splitter_core_tb;
    import qts_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int PRESSURE_RUN  = 30;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 40;
    localparam int MAX_PASSES_M  = 8;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_EOS,
        ROW_CONFIG
    } row_op_t;

    // one directed row; n_typed < 0 means the tokeniser model supplies the results
    typedef struct {
        row_op_t           op;
        logic [7:0]        b;
        int                n_typed;
        result_t [3:0]     typed;
        logic [4:0][7:0]   regs;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    in_item_t                in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    result_t                 out_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_WIDTH-1:0]    cfg_wdata = '0;

    quoted_token_splitter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // tokeniser model: its own copy of the registers and scan state
    logic [1:0]   flags_m      = '0;
    logic [7:0]   delim_m [REG_DELIMS] = '{default: 8'h00};
    scan_mode_t   mode_m       = MODE_SKIP;
    logic [7:0]   quote_m      = '0;
    logic [1:0]   esc_left_m   = '0;
    logic [8:0]   esc_val_m    = '0;
    logic         esc_inq_m    = 1'b0;
    logic         has_bytes_m  = 1'b0;

    result_t      step_out[$];          // results of the byte just modelled
    result_t      awaited_results[$];   // results still owed by the block
    in_item_t     text_q[$];            // generated text not yet sent

    cfg_reg_t     reg_order [5] = '{CFG_SKIP_FLAGS, CFG_DELIM_A, CFG_DELIM_B,
                                    CFG_DELIM_C, CFG_DELIM_D};

    int           errors       = 0;
    int           cycle_count  = 0;
    int           burst_left   = 0;
    bit           steady       = 1'b0;  // sender offers with no gaps
    bit           hold_off_req = 1'b0;  // asks the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // tokeniser model
    // ------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic bit is_octal(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_SEVEN;
    endfunction

    // only the first DELIM_SLOTS registers are looked at, zero means unused
    function automatic bit is_cut_byte(logic [7:0] b);
        for (int i = 0; i < DELIM_SLOTS; i++)
            if (delim_m[i] != 8'h00 && delim_m[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic result_t res(kind_t k, logic [7:0] b);
        result_t r;
        r.kind = k;
        r.out_byte = b;
        return r;
    endfunction

    // the block gives at most MAX_RESULTS results per byte
    task automatic push_out(kind_t k, logic [7:0] b);
        if (step_out.size() < MAX_RESULTS)
            step_out.push_back(res(k, b));
    endtask

    task automatic clear_scan();
        mode_m      = MODE_SKIP;
        quote_m     = '0;
        esc_left_m  = '0;
        esc_val_m   = '0;
        esc_inq_m   = 1'b0;
        has_bytes_m = 1'b0;
    endtask

    task automatic finish_escape(logic [7:0] b);
        push_out(KIND_BYTE, b);
        has_bytes_m = 1'b1;
        esc_left_m  = '0;
        esc_val_m   = '0;
        mode_m      = esc_inq_m ? MODE_QUOTED : MODE_PLAIN;
    endtask

    // one pass over a byte; again is set when the same byte is scanned once more
    task automatic scan_byte(input logic [7:0] b_in, output bit again);
        logic [7:0] b;
        b = b_in;
        again = 1'b0;
        case (mode_m)
            MODE_SKIP:
            begin
                if (b == CH_SPACE || b == CH_TAB)
                    again = 1'b0;
                else if (b == CH_LF)
                begin
                    if (flags_m[0])
                        push_out(KIND_STOP, b);
                end
                else if (b == CH_HASH && !flags_m[1])
                    mode_m = MODE_COMMENT;
                else if (is_blank(b))
                    push_out(KIND_STOP, b);
                else
                begin
                    has_bytes_m = 1'b0;
                    if (b == CH_DQUOTE || b == CH_SQUOTE)
                    begin
                        mode_m  = MODE_QUOTED;
                        quote_m = b;
                    end
                    else
                    begin
                        mode_m = MODE_PLAIN;
                        again  = 1'b1;
                    end
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_LF)
                begin
                    mode_m = MODE_SKIP;
                    again  = 1'b1;
                end
            end
            MODE_PLAIN:
            begin
                if (is_blank(b))
                begin
                    push_out(KIND_END, 8'h00);
                    mode_m = MODE_SKIP;
                end
                else if (b == CH_BSLASH)
                begin
                    mode_m    = MODE_ESC_FIRST;
                    esc_inq_m = 1'b0;
                end
                else if (is_cut_byte(b))
                begin
                    // a cut after token bytes rescans the delimiter between tokens
                    if (has_bytes_m)
                    begin
                        push_out(KIND_END, 8'h00);
                        again = 1'b1;
                    end
                    else
                    begin
                        push_out(KIND_BYTE, b);
                        push_out(KIND_END, 8'h00);
                    end
                    mode_m = MODE_SKIP;
                end
                else
                begin
                    push_out(KIND_BYTE, b);
                    has_bytes_m = 1'b1;
                end
            end
            MODE_QUOTED:
            begin
                if (b == quote_m)
                begin
                    push_out(KIND_END, 8'h00);
                    mode_m = MODE_SKIP;
                end
                else if (b == CH_BSLASH)
                begin
                    mode_m    = MODE_ESC_FIRST;
                    esc_inq_m = 1'b1;
                end
                else
                begin
                    push_out(KIND_BYTE, b);
                    has_bytes_m = 1'b1;
                end
            end
            MODE_ESC_FIRST:
            begin
                if (is_octal(b))
                begin
                    esc_val_m  = {6'd0, b[2:0]};
                    esc_left_m = 2'd2;
                    mode_m     = MODE_ESC_OCTAL;
                end
                else
                begin
                    case (b)
                        CH_LOW_N: b = CH_LF;
                        CH_LOW_B: b = CH_BS;
                        CH_LOW_T: b = CH_TAB;
                        CH_LOW_R: b = CH_CR;
                        default:  b = b;
                    endcase
                    finish_escape(b);
                end
            end
            MODE_ESC_OCTAL:
            begin
                if (is_octal(b))
                begin
                    // nine bits kept, the byte is the low eight
                    esc_val_m  = {esc_val_m[5:0], b[2:0]};
                    esc_left_m = esc_left_m - 2'd1;
                    if (esc_left_m == 2'd0)
                        finish_escape(esc_val_m[7:0]);
                end
                else
                begin
                    // octal cut short: value so far, then the byte goes round again
                    finish_escape(esc_val_m[7:0]);
                    again = 1'b1;
                end
            end
            default:
            begin
                mode_m = MODE_SKIP;
                again  = 1'b1;
            end
        endcase
    endtask

    task automatic tokenise_step(in_item_t it);
        bit again;
        step_out.delete();
        if (it.end_of_input)
        begin
            // pending octal digits still count, a bare backslash adds nothing
            if (mode_m == MODE_ESC_OCTAL)
                push_out(KIND_BYTE, esc_val_m[7:0]);
            if (mode_m == MODE_PLAIN || mode_m == MODE_QUOTED ||
                mode_m == MODE_ESC_FIRST || mode_m == MODE_ESC_OCTAL)
                push_out(KIND_END, 8'h00);
            push_out(KIND_EOS, 8'h00);
            clear_scan();
        end
        else
        begin
            for (int pass = 0; pass < MAX_PASSES_M; pass++)
            begin
                scan_byte(it.in_byte, again);
                if (!again)
                    break;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // outputs are sampled at the edge, before the block's own updates land
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch($sformatf("result kind %0d byte %02h with nothing awaited",
                                          out_data.kind, out_data.out_byte));
            else
            begin
                want = awaited_results.pop_front();
                if (out_data.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              out_data.kind, want.kind));
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("byte %02h, wanted %02h",
                                              out_data.out_byte, want.out_byte));
            end
        end
    end

    // hard stop well beyond the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern in segments, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : receiver_stall
        int seg;
        int duty;
        forever
        begin
            seg = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0:       duty = 0;
                1:       duty = 20;
                2:       duty = 50;
                default: duty = 85;
            endcase
            while (seg > 0 && !hold_off_req)
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < duty);
                seg--;
            end
            if (hold_off_req)
            begin
                // queue fills up behind this, so the input must stall
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offers one byte transaction in bursts with random gaps, none while steady; returns once it is taken
    task automatic send_item(in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic feed(in_item_t it, int n_typed, result_t [3:0] typed);
        send_item(it);
        tokenise_step(it);
        if (n_typed < 0)
            foreach (step_out[i])
                awaited_results.push_back(step_out[i]);
        else
            for (int i = 0; i < n_typed; i++)
                awaited_results.push_back(typed[i]);
    endtask

    // wait for every owed result, then let any result-free byte finish inside the block
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all five registers in back-to-back writes; only called while idle
    task automatic apply_config(logic [4:0][7:0] regs);
        cfg_we <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= reg_order[i];
            cfg_wdata <= regs[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        flags_m = regs[0][1:0];
        for (int i = 0; i < REG_DELIMS; i++)
            delim_m[i] = regs[i + 1];
    endtask

    // ------------------------------------------------------------------
    // random text
    // ------------------------------------------------------------------

    task automatic put_byte(logic [7:0] b);
        in_item_t it;
        it.in_byte      = b;
        it.end_of_input = 1'b0;
        text_q.push_back(it);
    endtask

    task automatic put_eos();
        in_item_t it;
        it.in_byte      = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        text_q.push_back(it);
    endtask

    task automatic put_escape();
        int n;
        put_byte(CH_BSLASH);
        case ($urandom_range(0, 5))
            0: put_byte(CH_LOW_N);
            1: put_byte(CH_LOW_B);
            2: put_byte(CH_LOW_T);
            3: put_byte(CH_LOW_R);
            4:
            begin
                n = $urandom_range(1, 3);
                repeat (n) put_byte(8'(CH_ZERO + $urandom_range(0, 7)));
            end
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    function automatic logic [7:0] pick_gap_byte();
        case ($urandom_range(0, 5))
            0, 1:    return CH_SPACE;
            2:       return CH_TAB;
            3:       return CH_LF;
            4:       return CH_CR;
            default: return 8'(8'h0B + $urandom_range(0, 1));  // vertical tab or form feed
        endcase
    endfunction

    // appends one piece of mostly well-formed text; the rest is noise or cut short
    task automatic add_piece();
        int n;
        logic [7:0] q;
        logic [7:0] b;
        logic [7:0] cut;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4:
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 7) == 0)
                        put_escape();
                    else
                        put_byte(8'($urandom_range(8'h21, 8'h7E)));
                end
                put_byte(pick_gap_byte());
            end
            5, 6:
            begin
                q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                put_byte(q);
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    b = 8'($urandom_range(8'h20, 8'hFF));
                    if ($urandom_range(0, 4) == 0)
                        put_escape();
                    else
                        put_byte((b == q || b == CH_BSLASH) ? CH_LOW_N : b);
                end
                put_byte(q);
                put_byte(CH_SPACE);
            end
            7:
            begin
                n = $urandom_range(1, 3);
                repeat (n) put_byte(pick_gap_byte());
            end
            8:
            begin
                // comment up to the next newline
                put_byte(CH_HASH);
                n = $urandom_range(0, 4);
                repeat (n)
                begin
                    b = 8'($urandom_range(0, 255));
                    put_byte(b == CH_LF ? CH_LOW_T : b);
                end
                put_byte(CH_LF);
            end
            9, 10:
            begin
                // delimiter inside a word, and standing alone
                cut = delim_m[2'($urandom_range(0, REG_DELIMS - 1))];
                if (cut == 8'h00)
                    cut = 8'h2C;
                put_byte(8'($urandom_range(8'h41, 8'h5A)));
                put_byte(cut);
                if ($urandom_range(0, 1))
                    put_byte(cut);
                put_byte(8'($urandom_range(8'h61, 8'h7A)));
                put_byte(CH_SPACE);
            end
            11:
            begin
                put_byte(8'($urandom_range(8'h61, 8'h7A)));
                put_escape();
                put_byte($urandom_range(0, 1) ? CH_SPACE : delim_m[0]);
            end
            12, 13:
            begin
                n = $urandom_range(1, 3);
                repeat (n) put_byte(8'($urandom_range(0, 255)));
            end
            14:
                put_eos();
            default:
            begin
                // string or escape cut off by end of stream
                put_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                put_byte(8'($urandom_range(8'h21, 8'h7E)));
                if ($urandom_range(0, 1))
                    put_byte(CH_BSLASH);
                if ($urandom_range(0, 1))
                    put_byte(8'(CH_ZERO + $urandom_range(0, 7)));
                put_eos();
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // directed rows
    // ------------------------------------------------------------------

    function automatic stim_row_t byte_row(logic [7:0] b, int n = -1, result_t r0 = '0,
                                           result_t r1 = '0, result_t r2 = '0);
        stim_row_t r;
        r.op       = ROW_BYTE;
        r.b        = b;
        r.n_typed  = n;
        r.typed[0] = r0;
        r.typed[1] = r1;
        r.typed[2] = r2;
        r.typed[3] = '0;
        r.regs     = '0;
        return r;
    endfunction

    function automatic stim_row_t eos_row(int n = -1, result_t r0 = '0, result_t r1 = '0,
                                          result_t r2 = '0);
        stim_row_t r;
        r = byte_row(8'h00, n, r0, r1, r2);
        r.op = ROW_EOS;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [4:0][7:0] regs);
        stim_row_t r;
        r = byte_row(8'h00);
        r.op   = ROW_CONFIG;
        r.regs = regs;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        stim_row_t        rows[$];
        in_item_t         it;
        logic [4:0][7:0]  regs;
        int               sent;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: no delimiters, plain skipping
        rows.push_back(eos_row(1, res(KIND_EOS, 8'h00)));
        rows.push_back(byte_row(8'h0B, 1, res(KIND_STOP, 8'h0B)));
        rows.push_back(byte_row(8'hFF, 1, res(KIND_BYTE, 8'hFF)));
        rows.push_back(byte_row(8'h00, 1, res(KIND_BYTE, 8'h00)));
        rows.push_back(byte_row(CH_TAB, 1, res(KIND_END, 8'h00)));
        // comment, closed by newline
        rows.push_back(byte_row(CH_HASH, 0));
        rows.push_back(byte_row(CH_LF, 0));
        // quoted string with a named escape and a three digit octal that overflows
        rows.push_back(byte_row(CH_SQUOTE));
        rows.push_back(byte_row(CH_BSLASH));
        rows.push_back(byte_row(CH_LOW_N));
        rows.push_back(byte_row(CH_BSLASH));
        rows.push_back(byte_row(CH_SEVEN));
        rows.push_back(byte_row(CH_SEVEN));
        rows.push_back(byte_row(CH_SEVEN));
        rows.push_back(byte_row(CH_SQUOTE));
        // bare backslash cut off by end of stream adds no byte
        rows.push_back(byte_row(CH_BSLASH));
        rows.push_back(eos_row(2, res(KIND_END, 8'h00), res(KIND_EOS, 8'h00)));
        // pending octal digit at end of stream still gives its value
        rows.push_back(byte_row(CH_BSLASH));
        rows.push_back(byte_row(8'h35));
        rows.push_back(eos_row(3, res(KIND_BYTE, 8'h05), res(KIND_END, 8'h00),
                               res(KIND_EOS, 8'h00)));
        // newline stops, hash starts a token, delimiters ',' ';' 0xff and blank
        rows.push_back(cfg_row({CH_SPACE, 8'hFF, 8'h3B, 8'h2C, 8'h03}));
        rows.push_back(byte_row(CH_LF, 1, res(KIND_STOP, CH_LF)));
        rows.push_back(byte_row(CH_HASH, 1, res(KIND_BYTE, CH_HASH)));
        rows.push_back(byte_row(8'h2C));
        // octal cut short by a delimiter: the most results from one byte
        rows.push_back(byte_row(CH_BSLASH));
        rows.push_back(byte_row(8'h31));
        rows.push_back(byte_row(8'h2C));
        // an escaped delimiter is just a token byte
        rows.push_back(byte_row(CH_BSLASH));
        rows.push_back(byte_row(8'h2C));
        rows.push_back(eos_row());

        foreach (rows[i])
        begin
            if (rows[i].op == ROW_CONFIG)
            begin
                settle();
                apply_config(rows[i].regs);
            end
            else
            begin
                it.in_byte      = rows[i].b;
                it.end_of_input = (rows[i].op == ROW_EOS);
                feed(it, rows[i].n_typed, rows[i].typed);
            end
        end

        // random text, one register setting per phase
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            case (phase)
                0:       regs = {8'h7C, 8'h3A, 8'h3B, 8'h2C, 8'h00};
                1:       regs = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03};
                2:       regs = {8'h00, 8'($urandom_range(8'h21, 8'h7E)),
                                 8'($urandom_range(8'h21, 8'h7E)),
                                 8'($urandom_range(8'h21, 8'h7E)), 8'h01};
                3:       regs = {CH_SPACE, CH_BSLASH, CH_DQUOTE, CH_HASH, 8'h02};
                4:       regs = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 3))};
                default: regs = '0;
            endcase
            apply_config(regs);
            text_q.delete();
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // long receiver hold-off while the sender keeps offering at full rate
                if (phase == 2 && sent == 0)
                begin
                    hold_off_req = 1'b1;
                    steady       = 1'b1;
                end
                if (phase == 2 && sent == PRESSURE_RUN)
                    steady = 1'b0;
                // sender pause until nothing is owed, same settings afterwards
                if (phase == 4 && sent == PHASE_ITEMS / 2)
                    settle();
                if (text_q.size() == 0)
                    add_piece();
                it = text_q.pop_front();
                feed(it, -1, '0);
                sent++;
            end
        end

        settle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
